>>> design/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and constants for the counting semaphore table.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int NUM_SEMS    = 16;
  localparam int SEM_W       = $clog2(NUM_SEMS);
  localparam int NUM_FIBERS  = 64;
  localparam int FIB_W       = $clog2(NUM_FIBERS);
  localparam int CNT_W       = 17;
  localparam int OP_W        = 2;
  localparam int ST_W        = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 17'd65536;

  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_WAIT    = 2'd2;
  localparam logic [OP_W-1:0] OP_POST    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_VALUE = 3'd1;
  localparam logic [ST_W-1:0] ST_SHARED    = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_SEM    = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;

  // A classified request as it waits between the front and the back.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEM_W-1:0] idx;
    logic [CNT_W-1:0] value;
    logic [FIB_W-1:0] fiber;
    logic             bad_value;
    logic             shared;
  } req_t;

  typedef struct packed {
    logic             empty;
    req_t             req;
  } mid_q_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             caller_blocks;
    logic             woken_valid;
    logic [FIB_W-1:0] woken_fiber;
    logic [CNT_W-1:0] count_after;
  } res_t;

endpackage

>>> design/csem_front.sv
// ----------------------------------------------------------------------------
// csem_front
// Accepts requests, runs the state-free init checks and holds the
// classified requests in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module csem_front import csem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [OP_W-1:0]  in_op,
  input  logic [SEM_W-1:0] in_sem_index,
  input  logic [CNT_W-1:0] in_init_count,
  input  logic             in_shared_request,
  input  logic [FIB_W-1:0] in_fiber_id,
  output mid_q_t           mid_q,
  input  logic             mid_pop
);

  req_t        buf_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        accept;
  logic        pop;
  req_t        req_new;

  assign in_full = (cnt_r == 2'd2);
  assign accept  = in_push && !in_full;
  assign pop     = mid_pop && (cnt_r != 2'd0);

  always_comb begin
    req_new.op        = in_op;
    req_new.idx       = in_sem_index;
    req_new.value     = in_init_count;
    req_new.fiber     = in_fiber_id;
    req_new.bad_value = (in_op == OP_INIT) && (in_init_count > COUNT_MAX);
    req_new.shared    = (in_op == OP_INIT) && in_shared_request;
  end

  always_comb begin
    case ({accept, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r[wr_ptr_r] <= req_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign mid_q.empty = (cnt_r == 2'd0);
  assign mid_q.req   = buf_r[rd_ptr_r];

endmodule

>>> design/csem_back.sv
// ----------------------------------------------------------------------------
// csem_back
// Executes requests against the slot tables and the fiber link memory in
// a fetch and an execute state, and queues the results for the receiver.
// ----------------------------------------------------------------------------
module csem_back import csem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mid_q_t           mid_q,
  output logic             mid_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [ST_W-1:0]  out_status,
  output logic             out_caller_blocks,
  output logic             out_woken_valid,
  output logic [FIB_W-1:0] out_woken_fiber,
  output logic [CNT_W-1:0] out_count_after
);

  localparam logic ST_FETCH = 1'b0;
  localparam logic ST_EXEC  = 1'b1;

  logic                state_r;

  // Slot tables.
  logic [NUM_SEMS-1:0] slot_valid_r;
  logic [NUM_SEMS-1:0] queue_ne_r;
  logic [CNT_W-1:0]    slot_count_r [NUM_SEMS];
  logic [FIB_W-1:0]    queue_head_r [NUM_SEMS];
  logic [FIB_W-1:0]    queue_tail_r [NUM_SEMS];
  logic [FIB_W-1:0]    link_mem [NUM_FIBERS];

  // Values fetched for the request in flight.
  req_t                req_r;
  logic                valid_q_r;
  logic                ne_q_r;
  logic [CNT_W-1:0]    cnt_q_r;
  logic [FIB_W-1:0]    head_q_r;
  logic [FIB_W-1:0]    tail_q_r;
  logic [FIB_W-1:0]    link_q_r;

  // Next slot entry and result.
  logic                nv_valid;
  logic                nv_ne;
  logic [CNT_W-1:0]    nv_cnt;
  logic [FIB_W-1:0]    nv_head;
  logic [FIB_W-1:0]    nv_tail;
  logic                link_we;
  res_t                res;

  // Result queue.
  res_t                obuf_r [2];
  logic                owr_r;
  logic                ord_r;
  logic [1:0]          ocnt_r;
  logic [1:0]          ocnt_nxt;
  logic                opush;
  logic                opop;
  res_t                ohead;

  logic                fetch;

  // One request is in flight at a time, so a free result entry at fetch
  // guarantees room when it completes.
  assign fetch   = (state_r == ST_FETCH) && !mid_q.empty && (ocnt_r != 2'd2);
  assign mid_pop = fetch;

  always_ff @(posedge clk) begin
    if (fetch) begin
      req_r     <= mid_q.req;
      valid_q_r <= slot_valid_r[mid_q.req.idx];
      ne_q_r    <= queue_ne_r[mid_q.req.idx];
      cnt_q_r   <= slot_count_r[mid_q.req.idx];
      head_q_r  <= queue_head_r[mid_q.req.idx];
      tail_q_r  <= queue_tail_r[mid_q.req.idx];
      link_q_r  <= link_mem[queue_head_r[mid_q.req.idx]];
    end
  end

  always_comb begin
    nv_valid          = valid_q_r;
    nv_ne             = ne_q_r;
    nv_cnt            = cnt_q_r;
    nv_head           = head_q_r;
    nv_tail           = tail_q_r;
    link_we           = 1'b0;
    res.status        = ST_OK;
    res.caller_blocks = 1'b0;
    res.woken_valid   = 1'b0;
    res.woken_fiber   = '0;
    res.count_after   = valid_q_r ? cnt_q_r : '0;
    if (req_r.op == OP_INIT) begin
      if (req_r.bad_value) begin
        res.status = ST_BAD_VALUE;
      end else if (req_r.shared) begin
        res.status = ST_SHARED;
      end else begin
        nv_valid        = 1'b1;
        nv_cnt          = req_r.value;
        nv_ne           = 1'b0;
        res.count_after = req_r.value;
      end
    end else if (!valid_q_r) begin
      res.status = ST_NO_SEM;
    end else begin
      case (req_r.op)
        OP_DESTROY: begin
          nv_valid        = 1'b0;
          nv_ne           = 1'b0;
          res.count_after = '0;
        end
        OP_WAIT: begin
          if (cnt_q_r == '0) begin
            if (ne_q_r) begin
              link_we = 1'b1;
            end else begin
              nv_head = req_r.fiber;
              nv_ne   = 1'b1;
            end
            nv_tail           = req_r.fiber;
            res.caller_blocks = 1'b1;
          end else begin
            nv_cnt          = cnt_q_r - CNT_W'(1);
            res.count_after = cnt_q_r - CNT_W'(1);
          end
        end
        default: begin
          if ((cnt_q_r == '0) && ne_q_r) begin
            if (head_q_r == tail_q_r) begin
              nv_ne = 1'b0;
            end else begin
              nv_head = link_q_r;
            end
            res.woken_valid = 1'b1;
            res.woken_fiber = head_q_r;
          end else if (cnt_q_r >= COUNT_MAX) begin
            res.status = ST_OVERFLOW;
          end else begin
            nv_cnt          = cnt_q_r + CNT_W'(1);
            res.count_after = cnt_q_r + CNT_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      slot_count_r[req_r.idx] <= nv_cnt;
      queue_head_r[req_r.idx] <= nv_head;
      queue_tail_r[req_r.idx] <= nv_tail;
      if (link_we) begin
        link_mem[tail_q_r] <= req_r.fiber;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FETCH;
      slot_valid_r <= '0;
      queue_ne_r   <= '0;
    end else begin
      case (state_r)
        ST_FETCH: begin
          if (fetch) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          slot_valid_r[req_r.idx] <= nv_valid;
          queue_ne_r[req_r.idx]   <= nv_ne;
          state_r                 <= ST_FETCH;
        end
        default: state_r <= ST_FETCH;
      endcase
    end
  end

  // Result queue.
  assign opush = (state_r == ST_EXEC);
  assign opop  = out_pop && (ocnt_r != 2'd0);

  always_comb begin
    case ({opush, opop})
      2'b10:   ocnt_nxt = ocnt_r + 2'd1;
      2'b01:   ocnt_nxt = ocnt_r - 2'd1;
      default: ocnt_nxt = ocnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      obuf_r[owr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (opush) begin
        owr_r <= !owr_r;
      end
      if (opop) begin
        ord_r <= !ord_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  assign ohead             = obuf_r[ord_r];
  assign out_empty         = (ocnt_r == 2'd0);
  assign out_status        = ohead.status;
  assign out_caller_blocks = ohead.caller_blocks;
  assign out_woken_valid   = ohead.woken_valid;
  assign out_woken_fiber   = ohead.woken_fiber;
  assign out_count_after   = ohead.count_after;

endmodule

>>> design/counting_semaphore_table.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Sixteen counting semaphores, each with a FIFO of waiting fibers.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port: a transfer happens on a clock
// edge with in_push high and in_full low. Each request gives exactly one
// result, presented on the out_ ports while out_empty is low and taken on
// an edge with out_pop high.
// A request passes through the input queue, a fetch state and an execute
// state before its result is visible. The back end fetches the slot entry
// and the link of the queue head, then executes and writes back, and takes
// no new request until the one in flight is done.
// Two-entry queues sit at the input and the output, so a request can be
// accepted while results wait. When the receiver stops popping, the result
// queue fills, execution halts and then the input queue fills and raises
// in_full; nothing is dropped.
// Reset marks every slot invalid and every wait queue empty; counts, queue
// pointers and links hold no defined value until written.
// ----------------------------------------------------------------------------
module counting_semaphore_table import csem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [OP_W-1:0]  in_op,
  input  logic [SEM_W-1:0] in_sem_index,
  input  logic [CNT_W-1:0] in_init_count,
  input  logic             in_shared_request,
  input  logic [FIB_W-1:0] in_fiber_id,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [ST_W-1:0]  out_status,
  output logic             out_caller_blocks,
  output logic             out_woken_valid,
  output logic [FIB_W-1:0] out_woken_fiber,
  output logic [CNT_W-1:0] out_count_after
);

  mid_q_t mid_q;
  logic   mid_pop;

  csem_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_op             (in_op),
    .in_sem_index      (in_sem_index),
    .in_init_count     (in_init_count),
    .in_shared_request (in_shared_request),
    .in_fiber_id       (in_fiber_id),
    .mid_q             (mid_q),
    .mid_pop           (mid_pop)
  );

  csem_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mid_q             (mid_q),
    .mid_pop           (mid_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_status        (out_status),
    .out_caller_blocks (out_caller_blocks),
    .out_woken_valid   (out_woken_valid),
    .out_woken_fiber   (out_woken_fiber),
    .out_count_after   (out_count_after)
  );

  // The back end never takes a request from an empty middle queue.
  a_mid_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_q.empty)
    else $error("request taken from empty middle queue");

  // A fetch is never directly followed by another fetch.
  a_fetch_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |=> !mid_pop)
    else $error("back end fetched in consecutive cycles");

  // An error result neither blocks nor wakes anybody.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |->
      (!out_caller_blocks && !out_woken_valid && out_woken_fiber == '0))
    else $error("error result carries a block or wake");

  // A wake only happens from a zero count and never with a block.
  a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_woken_valid) |->
      (out_count_after == '0 && !out_caller_blocks))
    else $error("wake with nonzero count or blocking caller");

endmodule

>>> tb/tb_counting_semaphore_table.sv
// ----------------------------------------------------------------------------
// tb_counting_semaphore_table
// Self-checking regression for the counting semaphore table.
// ----------------------------------------------------------------------------
// A short directed table covers the error codes, the count limits, FIFO wake
// order and re-initialization of a slot with waiters. Random traffic then
// runs init, destroy, wait and post on a few busy slots, with some noise
// spread over the whole table. Both handshake sides stall at random. Every
// accepted request is run through a behavioral copy of the semaphore table,
// and each popped result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_table;
  timeunit 1ns;
  timeprecision 1ps;
  import csem_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 700;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SEM_W-1:0] idx;
    logic [CNT_W-1:0] value;
    logic             shared;
    logic [FIB_W-1:0] fiber;
  } sem_req_t;

  typedef struct packed {
    sem_req_t req;
    logic     has_exp;
    res_t     res;
  } sem_vector_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [OP_W-1:0]  in_op = OP_INIT;
  logic [SEM_W-1:0] in_sem_index = '0;
  logic [CNT_W-1:0] in_init_count = '0;
  logic             in_shared_request = 1'b0;
  logic [FIB_W-1:0] in_fiber_id = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic             out_caller_blocks;
  logic             out_woken_valid;
  logic [FIB_W-1:0] out_woken_fiber;
  logic [CNT_W-1:0] out_count_after;

  // Shadow copy of the semaphore table.
  bit               slot_live   [NUM_SEMS];
  logic [CNT_W-1:0] slot_cnt    [NUM_SEMS];
  bit               waitq_busy  [NUM_SEMS];
  logic [FIB_W-1:0] waitq_head  [NUM_SEMS];
  logic [FIB_W-1:0] waitq_tail  [NUM_SEMS];
  logic [FIB_W-1:0] next_fiber  [NUM_FIBERS];
  bit               next_known  [NUM_FIBERS];

  res_t        pending_results [$];
  sem_vector_t dir_tbl [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          pop_hold = 0;
  bit          steady = 1'b0;

  counting_semaphore_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_op             (in_op),
    .in_sem_index      (in_sem_index),
    .in_init_count     (in_init_count),
    .in_shared_request (in_shared_request),
    .in_fiber_id       (in_fiber_id),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_status        (out_status),
    .out_caller_blocks (out_caller_blocks),
    .out_woken_valid   (out_woken_valid),
    .out_woken_fiber   (out_woken_fiber),
    .out_count_after   (out_count_after)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one request to the shadow table and returns its result.
  function automatic res_t apply_request(sem_req_t r);
    res_t             res;
    logic [CNT_W-1:0] cur;
    logic [FIB_W-1:0] h;
    res = '0;
    cur = slot_live[r.idx] ? slot_cnt[r.idx] : '0;
    res.status = ST_OK;
    res.count_after = cur;
    if (r.op == OP_INIT) begin
      if (r.value > COUNT_MAX) begin
        res.status = ST_BAD_VALUE;
      end else if (r.shared) begin
        res.status = ST_SHARED;
      end else begin
        slot_live[r.idx] = 1'b1;
        slot_cnt[r.idx] = r.value;
        waitq_busy[r.idx] = 1'b0;
        res.count_after = r.value;
      end
    end else if (!slot_live[r.idx]) begin
      res.status = ST_NO_SEM;
      res.count_after = '0;
    end else begin
      case (r.op)
        OP_DESTROY: begin
          slot_live[r.idx] = 1'b0;
          waitq_busy[r.idx] = 1'b0;
          res.count_after = '0;
        end
        OP_WAIT: begin
          if (cur == '0) begin
            if (waitq_busy[r.idx]) begin
              next_fiber[waitq_tail[r.idx]] = r.fiber;
              next_known[waitq_tail[r.idx]] = 1'b1;
            end else begin
              waitq_head[r.idx] = r.fiber;
              waitq_busy[r.idx] = 1'b1;
            end
            waitq_tail[r.idx] = r.fiber;
            res.caller_blocks = 1'b1;
          end else begin
            slot_cnt[r.idx] = cur - CNT_W'(1);
            res.count_after = cur - CNT_W'(1);
          end
        end
        default: begin
          if (cur == '0 && waitq_busy[r.idx]) begin
            // Direct handoff to the oldest waiter; the count stays at zero.
            h = waitq_head[r.idx];
            if (h == waitq_tail[r.idx]) waitq_busy[r.idx] = 1'b0;
            else waitq_head[r.idx] = next_fiber[h];
            res.woken_valid = 1'b1;
            res.woken_fiber = h;
          end else if (cur >= COUNT_MAX) begin
            res.status = ST_OVERFLOW;
          end else begin
            slot_cnt[r.idx] = cur + CNT_W'(1);
            res.count_after = cur + CNT_W'(1);
          end
        end
      endcase
    end
    return res;
  endfunction

  // Mostly well-formed traffic on four busy slots; noise uses every field freely.
  function automatic sem_req_t next_request(bit noise);
    sem_req_t r;
    int       roll;
    r.fiber = FIB_W'($urandom_range(0, NUM_FIBERS - 1));
    if (noise) begin
      r.op = OP_W'($urandom_range(0, 3));
      r.idx = SEM_W'($urandom_range(0, NUM_SEMS - 1));
      r.value = CNT_W'($urandom_range(0, 131071));
      r.shared = 1'($urandom_range(0, 1));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 12) r.op = OP_INIT;
      else if (roll < 16) r.op = OP_DESTROY;
      else if (roll < 58) r.op = OP_WAIT;
      else r.op = OP_POST;
      if ($urandom_range(0, 9) == 0) r.idx = SEM_W'($urandom_range(0, NUM_SEMS - 1));
      else r.idx = SEM_W'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 70) r.value = CNT_W'($urandom_range(0, 3));
      else if (roll < 80) r.value = CNT_W'($urandom_range(65534, 65536));
      else if (roll < 90) r.value = CNT_W'($urandom_range(65537, 131071));
      else r.value = CNT_W'($urandom_range(0, 131071));
      r.shared = ($urandom_range(0, 19) == 0);
    end
    // A post must not follow a link that no wait has written yet.
    if (r.op == OP_POST && slot_live[r.idx] && slot_cnt[r.idx] == '0 &&
        waitq_busy[r.idx] && waitq_head[r.idx] != waitq_tail[r.idx] &&
        !next_known[waitq_head[r.idx]]) begin
      r.op = OP_WAIT;
    end
    return r;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, logic [SEM_W-1:0] idx,
                         logic [CNT_W-1:0] value, logic shared,
                         logic [FIB_W-1:0] fiber, logic has_exp,
                         logic [ST_W-1:0] status, logic blocks, logic wv,
                         logic [FIB_W-1:0] wf, logic [CNT_W-1:0] cnt);
    sem_vector_t v;
    v.req = '{op, idx, value, shared, fiber};
    v.has_exp = has_exp;
    v.res = '{status, blocks, wv, wf, cnt};
    dir_tbl.push_back(v);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(sem_req_t r, logic has_exp, res_t fixed);
    res_t res;
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_op <= r.op;
    in_sem_index <= r.idx;
    in_init_count <= r.value;
    in_shared_request <= r.shared;
    in_fiber_id <= r.fiber;
    @(posedge clk);
    while (in_full) @(posedge clk);
    res = apply_request(r);
    pending_results.push_back(has_exp ? fixed : res);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_push <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      out_pop <= 1'b0;
    end else if (steady) begin
      out_pop <= 1'b1;
    end else if ($urandom_range(0, 99) < 1) begin
      // Long stall so both internal queues fill and in_full rises.
      pop_hold <= $urandom_range(8, 24);
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d, count %0d",
               out_status, out_count_after);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("caller_blocks", 32'(want.caller_blocks), 32'(out_caller_blocks));
        check_field("woken_valid", 32'(want.woken_valid), 32'(out_woken_valid));
        check_field("woken_fiber", 32'(want.woken_fiber), 32'(out_woken_fiber));
        check_field("count_after", 32'(want.count_after), 32'(out_count_after));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("counting_semaphore_table regression: fail");
    $finish;
  end

  initial begin
    sem_req_t req;
    //      op          idx value   sh fib exp status        blk wv wf  count
    add_row(OP_WAIT,    0,  0,      0, 0,  1, ST_NO_SEM,     0, 0, 0,  0);
    add_row(OP_POST,    15, 0,      0, 0,  1, ST_NO_SEM,     0, 0, 0,  0);
    add_row(OP_DESTROY, 7,  0,      0, 0,  1, ST_NO_SEM,     0, 0, 0,  0);
    add_row(OP_INIT,    0,  131071, 1, 63, 1, ST_BAD_VALUE,  0, 0, 0,  0);
    add_row(OP_INIT,    0,  65537,  0, 0,  1, ST_BAD_VALUE,  0, 0, 0,  0);
    add_row(OP_INIT,    0,  5,      1, 0,  1, ST_SHARED,     0, 0, 0,  0);
    add_row(OP_INIT,    0,  65536,  0, 0,  1, ST_OK,         0, 0, 0,  65536);
    add_row(OP_POST,    0,  0,      0, 0,  1, ST_OVERFLOW,   0, 0, 0,  65536);
    add_row(OP_WAIT,    0,  0,      0, 63, 1, ST_OK,         0, 0, 0,  65535);
    add_row(OP_INIT,    0,  65537,  0, 0,  1, ST_BAD_VALUE,  0, 0, 0,  65535);
    add_row(OP_INIT,    0,  3,      1, 0,  1, ST_SHARED,     0, 0, 0,  65535);
    add_row(OP_INIT,    15, 0,      0, 0,  1, ST_OK,         0, 0, 0,  0);
    add_row(OP_WAIT,    15, 0,      0, 63, 1, ST_OK,         1, 0, 0,  0);
    add_row(OP_WAIT,    15, 0,      0, 42, 1, ST_OK,         1, 0, 0,  0);
    add_row(OP_WAIT,    15, 0,      0, 21, 1, ST_OK,         1, 0, 0,  0);
    add_row(OP_POST,    15, 0,      0, 0,  1, ST_OK,         0, 1, 63, 0);
    add_row(OP_WAIT,    15, 0,      0, 0,  1, ST_OK,         1, 0, 0,  0);
    add_row(OP_POST,    15, 0,      0, 0,  1, ST_OK,         0, 1, 42, 0);
    add_row(OP_POST,    15, 0,      0, 0,  1, ST_OK,         0, 1, 21, 0);
    add_row(OP_POST,    15, 0,      0, 0,  1, ST_OK,         0, 1, 0,  0);
    add_row(OP_POST,    15, 0,      0, 0,  1, ST_OK,         0, 0, 0,  1);
    add_row(OP_WAIT,    15, 0,      0, 5,  0, ST_OK,         0, 0, 0,  0);
    add_row(OP_WAIT,    15, 0,      0, 9,  0, ST_OK,         0, 0, 0,  0);
    // Re-initializing a slot drops its waiter.
    add_row(OP_INIT,    15, 2,      0, 0,  1, ST_OK,         0, 0, 0,  2);
    add_row(OP_DESTROY, 15, 0,      0, 0,  1, ST_OK,         0, 0, 0,  0);
    add_row(OP_POST,    15, 0,      0, 0,  1, ST_NO_SEM,     0, 0, 0,  0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tbl[i]) send_request(dir_tbl[i].req, dir_tbl[i].has_exp, dir_tbl[i].res);
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 300 && n < 420);
      if (n == 200 || n == 550) hold_until_drained();
      req = next_request($urandom_range(0, 9) == 0);
      send_request(req, 1'b0, '0);
    end
    in_push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("counting_semaphore_table regression: pass");
    end else begin
      $display("counting_semaphore_table regression: fail");
    end
    $finish;
  end

endmodule
